>>> src/kmde_pkg.sv
// ----------------------------------------------------------------------------
// kmde_pkg
// Shared field widths, operation codes and the key event type of the key
// matrix debounce block.
// ----------------------------------------------------------------------------
package kmde_pkg;

	localparam int OPC_W  = 2;
	localparam int ROW_W  = 3;
	localparam int COL_W  = 3;
	localparam int TIME_W = 32;

	localparam logic [OPC_W-1:0] OP_SAMPLE = 2'd0;
	localparam logic [OPC_W-1:0] OP_SCAN   = 2'd1;
	localparam logic [OPC_W-1:0] OP_TAKE   = 2'd2;

	localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd1000;

	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic             action;
	} key_event_t;

endpackage

>>> src/kmde_in_if.sv
// ----------------------------------------------------------------------------
// kmde_in_if
// Request channel: key samples, end-of-scan service and take requests.
// ----------------------------------------------------------------------------
interface kmde_in_if import kmde_pkg::*; ();

	logic              valid;
	logic              ready;
	logic [OPC_W-1:0]  opcode;
	logic [ROW_W-1:0]  row_index;
	logic [COL_W-1:0]  col_index;
	logic              pressed;
	logic [TIME_W-1:0] now_us;

	modport source (
		output valid, opcode, row_index, col_index, pressed, now_us,
		input  ready
	);

	modport sink (
		input  valid, opcode, row_index, col_index, pressed, now_us,
		output ready
	);

endinterface

>>> src/kmde_out_if.sv
// ----------------------------------------------------------------------------
// kmde_out_if
// Status channel: one status word for every request.
// ----------------------------------------------------------------------------
interface kmde_out_if import kmde_pkg::*; #(
	parameter int CNT_W = 6
) ();

	logic             valid;
	logic             ready;
	logic             event_present;
	logic [ROW_W-1:0] event_row;
	logic [COL_W-1:0] event_col;
	logic             event_action;
	logic             taken;
	logic             dropped;
	logic [CNT_W-1:0] pending_count;

	modport source (
		output valid, event_present, event_row, event_col, event_action,
		       taken, dropped, pending_count,
		input  ready
	);

	modport sink (
		input  valid, event_present, event_row, event_col, event_action,
		       taken, dropped, pending_count,
		output ready
	);

endinterface

>>> src/key_matrix_debounce_events.sv
// ----------------------------------------------------------------------------
// key_matrix_debounce_events
// Debounces raw key matrix samples, turns accepted level changes into key
// events and hands them out through a holding slot and a pending queue.
// ----------------------------------------------------------------------------
//  Channel    Dir   Content
//  in_ch      in    opcode, row_index, col_index, pressed, now_us
//  out_ch     out   event_present, event_row, event_col, event_action,
//                   taken, dropped, pending_count
//  cfg        in    cfg_we, cfg_wdata (debounce timeout)
//
// One request is taken per cycle unless out_ch stalls or the key table is
// being cleared; its status word is registered behind the request register.
// The key table and the pending queue are memories with registered reads.
// After reset the key table is cleared entry by entry, during which
// in_ch.ready is low. A stalled out_ch holds the request register and then
// stops further transfers on in_ch.
// ----------------------------------------------------------------------------
module key_matrix_debounce_events import kmde_pkg::*; #(
	parameter int ROWS          = 5,
	parameter int COLS          = 8,
	parameter int PENDING_DEPTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [TIME_W-1:0] cfg_wdata,
	kmde_in_if.sink           in_ch,
	kmde_out_if.source        out_ch
);

	localparam int KEYS   = ROWS * COLS;
	localparam int KEY_AW = (KEYS > 1) ? $clog2(KEYS) : 1;
	localparam int PTR_W  = $clog2(PENDING_DEPTH);
	localparam int CNT_W  = $clog2(PENDING_DEPTH + 1);

	typedef struct packed {
		logic              level;
		logic [TIME_W-1:0] stamp;
	} key_entry_t;

	// Configuration and clearing pass
	logic [TIME_W-1:0] timeout_q;
	logic              clearing_q;
	logic [KEY_AW-1:0] clr_cnt_q;

	// Request stage
	logic              valid_s1;
	logic [OPC_W-1:0]  opcode_s1;
	logic              in_range_s1;
	logic [KEY_AW-1:0] key_idx_s1;
	logic [ROW_W-1:0]  row_s1;
	logic [COL_W-1:0]  col_s1;
	logic              pressed_s1;
	logic [TIME_W-1:0] now_s1;
	key_entry_t        key_rd_s1;

	// Event state
	logic              held_valid_q;
	key_event_t        held_ev_q;
	logic [PTR_W-1:0]  head_q;
	logic [PTR_W-1:0]  tail_q;
	logic [CNT_W-1:0]  fill_q;
	key_event_t        head_rd_q;

	// Status register
	logic              out_valid_q;
	logic              present_q;
	key_event_t        shown_q;
	logic              taken_q;
	logic              dropped_q;
	logic [CNT_W-1:0]  count_q;

	key_entry_t        key_mem [KEYS];
	key_event_t        fifo_mem [PENDING_DEPTH];

	logic              in_acc;
	logic              s1_adv;
	logic              in_range;
	logic [KEY_AW-1:0] rd_addr;
	logic              change;
	logic              key_we;
	logic [KEY_AW-1:0] key_wa;
	key_entry_t        key_wd;
	key_event_t        new_ev;
	logic              push;
	logic              pop;
	logic              take;
	logic              drop;
	logic              held_valid_d;
	key_event_t        held_ev_d;
	logic [PTR_W-1:0]  head_d;
	logic [PTR_W-1:0]  tail_d;
	logic [CNT_W-1:0]  fill_d;
	key_event_t        shown_d;
	logic [TIME_W-1:0] elapsed;

	assign s1_adv       = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready  = !clearing_q && (!valid_s1 || s1_adv);
	assign in_acc       = in_ch.valid && in_ch.ready;

	assign in_range = (32'(in_ch.row_index) < 32'(ROWS)) &&
		(32'(in_ch.col_index) < 32'(COLS));
	assign rd_addr  = in_range ?
		KEY_AW'(32'(in_ch.row_index) * COLS + 32'(in_ch.col_index)) : '0;

	assign elapsed = now_s1 - key_rd_s1.stamp;
	assign change  = (opcode_s1 == OP_SAMPLE) && in_range_s1 &&
		(pressed_s1 != key_rd_s1.level) && (elapsed > timeout_q);

	assign new_ev.row    = row_s1;
	assign new_ev.col    = col_s1;
	assign new_ev.action = pressed_s1;

	always_comb begin
		push         = 1'b0;
		pop          = 1'b0;
		take         = 1'b0;
		drop         = 1'b0;
		held_valid_d = held_valid_q;
		held_ev_d    = held_ev_q;
		head_d       = head_q;
		tail_d       = tail_q;
		fill_d       = fill_q;
		if (s1_adv) begin
			unique case (opcode_s1)
				OP_SAMPLE: begin
					if (change) begin
						if (!held_valid_q) begin
							held_valid_d = 1'b1;
							held_ev_d    = new_ev;
						end else if (fill_q == CNT_W'(PENDING_DEPTH)) begin
							drop = 1'b1;
						end else begin
							push = 1'b1;
						end
					end
				end
				OP_SCAN: begin
					if (!held_valid_q && fill_q != '0) begin
						pop          = 1'b1;
						held_valid_d = 1'b1;
						held_ev_d    = head_rd_q;
					end
				end
				OP_TAKE: begin
					if (held_valid_q) begin
						take         = 1'b1;
						held_valid_d = 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
		if (push) begin
			tail_d = (tail_q == PTR_W'(PENDING_DEPTH - 1)) ? '0 : tail_q + 1'b1;
			fill_d = fill_q + 1'b1;
		end
		if (pop) begin
			head_d = (head_q == PTR_W'(PENDING_DEPTH - 1)) ? '0 : head_q + 1'b1;
			fill_d = fill_q - 1'b1;
		end
		if (take) begin
			shown_d = held_ev_q;
		end else if (held_valid_d) begin
			shown_d = held_ev_d;
		end else begin
			shown_d = '0;
		end
	end

	assign key_we       = clearing_q || (s1_adv && change);
	assign key_wa       = clearing_q ? clr_cnt_q : key_idx_s1;
	assign key_wd.level = clearing_q ? 1'b0 : pressed_s1;
	assign key_wd.stamp = clearing_q ? '0 : now_s1;

	always_ff @(posedge clk) begin
		if (key_we) begin
			key_mem[key_wa] <= key_wd;
		end
		if (in_acc) begin
			key_rd_s1 <= (key_we && key_wa == rd_addr) ? key_wd : key_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_mem[tail_q] <= new_ev;
		end
		head_rd_q <= (push && tail_q == head_d) ? new_ev : fifo_mem[head_d];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q  <= TIMEOUT_RESET;
			clearing_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else begin
			if (cfg_we) begin
				timeout_q <= cfg_wdata;
			end
			if (clearing_q) begin
				if (clr_cnt_q == KEY_AW'(KEYS - 1)) begin
					clearing_q <= 1'b0;
				end
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			out_valid_q  <= 1'b0;
			held_valid_q <= 1'b0;
			head_q       <= '0;
			tail_q       <= '0;
			fill_q       <= '0;
		end else begin
			if (in_acc) begin
				valid_s1 <= 1'b1;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
			if (s1_adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			held_valid_q <= held_valid_d;
			head_q       <= head_d;
			tail_q       <= tail_d;
			fill_q       <= fill_d;
		end
	end

	always_ff @(posedge clk) begin
		held_ev_q <= held_ev_d;
		if (in_acc) begin
			opcode_s1   <= in_ch.opcode;
			in_range_s1 <= in_range;
			key_idx_s1  <= rd_addr;
			row_s1      <= in_ch.row_index;
			col_s1      <= in_ch.col_index;
			pressed_s1  <= in_ch.pressed;
			now_s1      <= in_ch.now_us;
		end
		if (s1_adv) begin
			present_q <= held_valid_d;
			shown_q   <= shown_d;
			taken_q   <= take;
			dropped_q <= drop;
			count_q   <= fill_d;
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.event_present = present_q;
	assign out_ch.event_row     = shown_q.row;
	assign out_ch.event_col     = shown_q.col;
	assign out_ch.event_action  = shown_q.action;
	assign out_ch.taken         = taken_q;
	assign out_ch.dropped       = dropped_q;
	assign out_ch.pending_count = count_q;

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(PENDING_DEPTH))
		else $error("pending queue fill exceeds its depth");

	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && dropped_q) |-> (count_q == CNT_W'(PENDING_DEPTH)))
		else $error("event dropped while the pending queue had room");

	a_take_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && taken_q) |-> !present_q)
		else $error("holding slot still full after a take");

	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> !in_ch.ready)
		else $error("request transfer offered during the key table clear");

	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (fill_q == $past(fill_q) - 1'b1))
		else $error("pending count did not fall after a pop");
`endif

endmodule
